@@ hw/rtl/fsdp_pkg.sv @@
// package for the format string decimal printer
// character codes, bcd cell control type and stream field widths; no dependencies
package fsdp_pkg;

  // format and output character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  // double dabble correction: digits of five and up get three added before the shift
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;
  localparam logic [3:0] BCD_ZERO    = 4'd0;

  // stream field widths
  localparam int CHAR_W     = 8;
  localparam int ARG_W      = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 1;

  // control shared by every cell of the digit chain
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // correct and shift in one binary bit
    logic shift;   // take the digit of the lower neighbor
  } cell_ctl_t;

endpackage

@@ hw/rtl/fsdp_bcd_cell.sv @@
// one bcd digit cell of the decimal conversion chain
// depends on fsdp_pkg for the cell control type and bcd constants
module fsdp_bcd_cell (
  input  logic               clk,
  input  fsdp_pkg::cell_ctl_t ctl,
  input  logic               bit_in,
  output logic               bit_out,
  input  logic [3:0]         digit_in,
  output logic [3:0]         digit
);
  import fsdp_pkg::*;

  logic [3:0] adj;

  always_comb begin
    adj     = (digit >= BCD_ADJ_MIN) ? (digit + BCD_ADJ) : digit;
    bit_out = adj[3];
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= BCD_ZERO;
    end else if (ctl.dabble) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

@@ hw/rtl/format_string_decimal_printer_unit.sv @@
// top level of the format string decimal printer: control, magnitude shifter, output register
// depends on fsdp_pkg and fsdp_bcd_cell
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: fmt_char[7:0], arg_value[39:8]
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: out_char[7:0], tlast: last, tuser: error
//
// an ordinary byte, a percent or a nul is handled in the idle state
// a %d loads the magnitude, runs bit-serial double dabble through the chain of bcd cells,
//   then skips each leading zero and sends each character (sign plus up to NDIG digits)
// an output stall holds the emit state; the input side is ready only when idle with the
//   output register free or being drained, and always once halted (items are dropped)
// rst is synchronous, active high, and clears the pending percent and the halt
module format_string_decimal_printer_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // fmt_char [7:0], arg_value [39:8]
  input  logic [fsdp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // out_char [7:0]
  output logic [fsdp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // error [0]
  output logic [fsdp_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);
  import fsdp_pkg::*;

  // enough digits for the magnitude of the most negative value
  localparam int NDIG  = (VALUE_BITS * 3) / 10 + 1;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int REM_W = $clog2(NDIG + 1);
  localparam logic [VALUE_BITS-1:0] ONE_V = VALUE_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT,
    ST_HALT
  } state_t;

  state_t state;

  // control registers
  logic             pending;    // percent seen, conversion byte expected
  logic             sign_pend;  // minus sign still to send
  logic             seen;       // a nonzero digit has been sent
  logic [CNT_W-1:0] cnt;        // conversion bits left minus one
  logic [REM_W-1:0] rem;        // digits left in the chain

  // magnitude shifted msb first into the chain
  logic [VALUE_BITS-1:0] mag;

  // output register
  logic             m_valid;
  logic [CHAR_W-1:0] m_char;
  logic             m_last;
  logic             m_err;

  // input fields
  logic [CHAR_W-1:0]            fmt_char;
  logic signed [ARG_W-1:0]      arg_value;
  logic signed [VALUE_BITS-1:0] arg_v;
  logic                         arg_neg;
  logic [VALUE_BITS-1:0]        arg_mag;

  // chain wiring
  cell_ctl_t        cell_ctl;
  logic [3:0]       digits [NDIG];
  logic [NDIG-1:0]  carry;
  logic [3:0]       top_digit;

  logic load_ok;
  logic in_acc;
  logic skip;
  logic emit_dig;
  logic m_load;

  always_comb begin
    fmt_char  = s_axis_tdata[CHAR_W-1:0];
    arg_value = s_axis_tdata[CHAR_W +: ARG_W];
    // low VALUE_BITS bits, sign extended when VALUE_BITS is wider than the field
    arg_v     = VALUE_BITS'(arg_value);
    arg_neg   = arg_v[VALUE_BITS-1];
    // most negative value still comes out right as an unsigned magnitude
    arg_mag   = arg_neg ? (~arg_v + ONE_V) : arg_v;
  end

  always_comb begin
    load_ok       = !m_valid || m_axis_tready;
    s_axis_tready = ((state == ST_IDLE) && load_ok) || (state == ST_HALT);
    in_acc        = s_axis_tvalid && s_axis_tready;
    top_digit     = digits[NDIG-1];
    // leading zeros are dropped, but the last digit always goes out
    skip          = (state == ST_EMIT) && !sign_pend && !seen &&
                    (top_digit == BCD_ZERO) && (rem != REM_W'(1));
    emit_dig      = (state == ST_EMIT) && !sign_pend && !skip && load_ok;
    // output register takes a new item: echo or error byte, minus sign, or a digit
    m_load        = ((state == ST_IDLE) && in_acc && (fmt_char != CH_NUL) &&
                     (pending ? (fmt_char != CH_D) : (fmt_char != CH_PERCENT))) ||
                    ((state == ST_EMIT) && sign_pend && load_ok) || emit_dig;
  end

  always_comb begin
    cell_ctl = '0;
    unique case (state)
      ST_IDLE: begin
        cell_ctl.clear = in_acc && pending && (fmt_char == CH_D);
      end
      ST_CONVERT: begin
        cell_ctl.dabble = 1'b1;
      end
      ST_EMIT: begin
        cell_ctl.shift = skip || emit_dig;
      end
      ST_HALT: begin
        cell_ctl = '0;
      end
      default: begin
        cell_ctl = '0;
      end
    endcase
  end

  // row of bcd cells: bits ripple up one cell per cycle while converting, digits move up
  // one cell per cycle while emitting, as long as a digit is skipped or sent without stall
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    fsdp_bcd_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .bit_in   ((i == 0) ? mag[VALUE_BITS-1] : carry[(i == 0) ? 0 : i - 1]),
      .bit_out  (carry[i]),
      .digit_in ((i == 0) ? BCD_ZERO : digits[(i == 0) ? 0 : i - 1]),
      .digit    (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      sign_pend <= 1'b0;
      seen      <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      m_valid <= m_load || (m_valid && !m_axis_tready);
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (fmt_char != CH_NUL)) begin
            if (pending) begin
              pending <= 1'b0;
              if (fmt_char == CH_D) begin
                mag       <= arg_mag;
                sign_pend <= arg_neg;
                cnt       <= CNT_W'(VALUE_BITS - 1);
                state     <= ST_CONVERT;
              end else begin
                // unknown conversion: report the byte and stop
                m_char  <= fmt_char;
                m_last  <= 1'b1;
                m_err   <= 1'b1;
                state   <= ST_HALT;
              end
            end else if (fmt_char == CH_PERCENT) begin
              pending <= 1'b1;
            end else begin
              m_char  <= fmt_char;
              m_last  <= 1'b1;
              m_err   <= 1'b0;
            end
          end
        end
        ST_CONVERT: begin
          mag <= {mag[VALUE_BITS-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            rem   <= REM_W'(NDIG);
            seen  <= 1'b0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sign_pend) begin
            if (load_ok) begin
              m_char    <= CH_MINUS;
              m_last    <= 1'b0;
              m_err     <= 1'b0;
              sign_pend <= 1'b0;
            end
          end else if (skip) begin
            rem <= rem - REM_W'(1);
          end else if (emit_dig) begin
            m_char  <= CH_ZERO + {4'b0000, top_digit};
            m_last  <= (rem == REM_W'(1));
            m_err   <= 1'b0;
            seen    <= 1'b1;
            rem     <= rem - REM_W'(1);
            if (rem == REM_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_HALT: begin
          state <= ST_HALT;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid   = m_valid;
  assign m_axis_tdata    = m_char;
  assign m_axis_tlast    = m_last;
  assign m_axis_tuser[0] = m_err;

  // the chain is deep enough: nothing leaves the top cell while converting
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONVERT) |-> !carry[NDIG-1])
    else $error("bcd chain overflow");

  // an error item is only ever produced on the way into the halt
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_err) |-> (state == ST_HALT))
    else $error("error item without halt");

  // halt is left only through reset
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HALT) |=> (state == ST_HALT))
    else $error("left halt without reset");

  // emission never runs out of digits before the last one is sent
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rem != '0))
    else $error("digit count underflow");

  // a digit item marked last ends the conversion
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_EMIT && state == ST_IDLE) |-> (m_valid && m_last))
    else $error("conversion ended without a last digit");

endmodule

@@ test/tb.sv @@
// testbench for format_string_decimal_printer_unit: drives format bytes with arguments,
// predicts the printed characters and checks every output item in order
// depends on fsdp_pkg and the printer rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsdp_pkg::*;

  localparam int VALUE_BITS   = ARG_W;
  localparam int RANDOM_ITEMS = 120;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_MAX   = 20;
  localparam logic [31:0] DEC_RADIX = 32'd10;

  // one printed character as it leaves the block
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } printed_char_t;

  // printf-style predictor and the queue of characters it still waits for
  class printf_checker;
    printed_char_t expected_chars[$];
    bit            pct_armed;
    bit            stopped;
    int            mismatches;

    function int outstanding();
      return expected_chars.size();
    endfunction

    function void push_char(logic [CHAR_W-1:0] c, logic l, logic e);
      printed_char_t p;
      p.ch   = c;
      p.last = l;
      p.err  = e;
      expected_chars.push_back(p);
    endfunction

    // signed decimal, most significant digit first, last digit marked
    function void push_decimal(logic [ARG_W-1:0] raw);
      logic [31:0] mag;
      logic [3:0]  digits[0:23];
      int          nd;
      nd  = 0;
      mag = raw[ARG_W-1] ? (~raw + 32'd1) : raw;
      do begin
        digits[nd] = 4'(mag % DEC_RADIX);
        nd++;
        mag = mag / DEC_RADIX;
      end while (mag != 32'd0);
      if (raw[ARG_W-1])
        push_char(CH_MINUS, 1'b0, 1'b0);
      for (int i = nd - 1; i >= 0; i--)
        push_char(CH_ZERO + CHAR_W'(digits[i]), (i == 0), 1'b0);
    endfunction

    // one accepted format byte
    function void note_format_byte(logic [CHAR_W-1:0] c, logic [ARG_W-1:0] a);
      if (stopped || c == CH_NUL)
        return;
      if (pct_armed) begin
        pct_armed = 1'b0;
        if (c == CH_D) begin
          push_decimal(a);
        end else begin
          stopped = 1'b1;
          push_char(c, 1'b1, 1'b1);
        end
      end else if (c == CH_PERCENT) begin
        pct_armed = 1'b1;
      end else begin
        push_char(c, 1'b1, 1'b0);
      end
    endfunction

    task report(string what, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // one accepted output item against the oldest expectation
    task check_output_char(logic [CHAR_W-1:0] c, logic l, logic e);
      printed_char_t p;
      if (expected_chars.size() == 0) begin
        report("unexpected char", c, '0);
        return;
      end
      p = expected_chars.pop_front();
      if (c !== p.ch)   report("out_char", c, p.ch);
      if (l !== p.last) report("last", CHAR_W'(l), CHAR_W'(p.last));
      if (e !== p.err)  report("error", CHAR_W'(e), CHAR_W'(p.err));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;

  printf_checker chk = new();

  bit tx_quiet = 1'b0;     // no sender gaps while set
  bit rx_quiet = 1'b0;     // no receiver stalls while set
  int rx_stall = 0;
  int idle_cycles = 0;

  format_string_decimal_printer_unit #(.VALUE_BITS(VALUE_BITS)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),    // fmt_char [7:0], arg_value [39:8]
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // out_char [7:0]
    .m_axis_tuser  (m_axis_tuser),    // error [0]
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random argument: full range, small values, both extremes, random widths
  function automatic logic [ARG_W-1:0] pick_arg();
    logic [ARG_W-1:0] a;
    case ($urandom_range(0, 5))
      0: a = $urandom();
      1: a = $urandom_range(0, 9);
      2: a = -$urandom_range(0, 99);
      3: a = 32'h8000_0000 + $urandom_range(0, 3);
      4: a = 32'h7fff_ffff - $urandom_range(0, 3);
      default: begin
        a = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) a = -a;
      end
    endcase
    return a;
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_PERCENT);
    return c;
  endfunction

  // output side: check on every handshake, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        chk.check_output_char(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      if (rx_stall > 0 && !rx_quiet) begin
        m_axis_tready <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        rx_stall <= rx_quiet ? 0 : idle_span();
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one format byte with its argument; returns after the accepting edge
  task send_byte(logic [CHAR_W-1:0] c, logic [ARG_W-1:0] a);
    int gap;
    gap = tx_quiet ? 0 : idle_span();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {a, c};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chk.note_format_byte(c, a);
  endtask

  task print_int(logic [ARG_W-1:0] a);
    send_byte(CH_PERCENT, $urandom());
    send_byte(CH_D, a);
  endtask

  // hold the sender until every predicted char has come out
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (chk.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int counted;
    int kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte extremes, nul, zero, both argument extremes, nul while armed
    send_byte("A", 32'h0);
    send_byte(8'hff, 32'hffff_ffff);
    send_byte(8'h01, 32'h5555_5555);
    send_byte(8'h80, 32'haaaa_aaaa);
    send_byte(CH_NUL, 32'h1234_5678);
    print_int(32'd0);
    print_int(32'h8000_0000);
    print_int(32'h7fff_ffff);
    print_int(32'hffff_ffff);
    send_byte(CH_PERCENT, 32'd0);
    send_byte(CH_NUL, 32'd99);
    send_byte(CH_D, 32'd12345);
    send_byte(CH_D, 32'd7);
    print_int(32'd7);
    print_int(-32'sd10);
    wait_drained();

    // random: mostly plain chars and conversions with random arguments
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= 70 && counted < 100) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end else begin
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
      end
      if (counted >= 60 && counted < 62)
        wait_drained();
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_byte(plain_char(), $urandom());
        counted++;
      end else if (kind < 85) begin
        print_int(pick_arg());
        counted += 2;
      end else if (kind < 93) begin
        send_byte(CH_NUL, $urandom());
      end else if (kind < 97) begin
        send_byte(CH_PERCENT, $urandom());
        send_byte(CH_NUL, $urandom());
        send_byte(CH_D, pick_arg());
        counted += 2;
      end else begin
        send_byte(CH_D, $urandom());
        counted++;
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // percent after percent halts the block; everything after is dropped
    send_byte("x", 32'd1);
    send_byte(CH_PERCENT, 32'd0);
    send_byte(CH_PERCENT, 32'd0);
    send_byte("y", 32'd2);
    print_int(32'd42);
    send_byte(8'hff, 32'hffff_ffff);

    s_axis_tvalid <= 1'b0;
    while (chk.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0 && chk.outstanding() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
